// File: rtl/spm_pkg.sv
// Package with the shared types, field widths and codes of the Sv39 page table mapper.
package spm_pkg;

    localparam int VA_W     = 39;
    localparam int PA_W     = 56;
    localparam int FLAGS_W  = 10;
    localparam int LEVEL_W  = 2;
    localparam int STATUS_W = 2;
    localparam int ADDED_W  = 2;
    localparam int PTE_W    = 64;
    localparam int PPN_W    = 44;
    localparam int VPN_W    = 9;
    localparam int PPN_LSB  = 10;
    localparam int PTE_PAD_W = PTE_W - PPN_W - PPN_LSB;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int PTE_V_BIT = 0;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP = 2'd2;

    typedef struct packed {
        logic clr;
        logic idle;
        logic rd;
        logic eval;
        logic leaf;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic req_valid;
        logic top;
        logic err;
        logic last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/spm_if.sv
// Channel interfaces of the Sv39 page table mapper: request, response and configuration.
interface spm_req_if import spm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VA_W-1:0]    virt_addr;
    logic [PA_W-1:0]    phys_addr;
    logic [FLAGS_W-1:0] leaf_flags;
    logic [LEVEL_W-1:0] leaf_level;

    modport source (output valid, output virt_addr, output phys_addr, output leaf_flags,
                    output leaf_level, input ready);
    modport sink (input valid, input virt_addr, input phys_addr, input leaf_flags,
                  input leaf_level, output ready);
endinterface

interface spm_rsp_if import spm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PTE_W-1:0]    leaf_entry;
    logic [ADDED_W-1:0]  pages_added;

    modport source (output valid, output status, output leaf_entry, output pages_added,
                    input ready);
    modport sink (input valid, input status, input leaf_entry, input pages_added,
                  output ready);
endinterface

interface spm_cfg_if import spm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PPN_W-1:0] pool_base_page;

    modport source (output valid, output pool_base_page, input ready);
    modport sink (input valid, input pool_base_page, output ready);
endinterface

// File: rtl/spm_ctrl.sv
// Controller state machine that sequences the clearing pass and the table walk.
module spm_ctrl import spm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_LEAF  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_sts.req_valid) begin
                    n_state = i_sts.top ? S_LEAF : S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.err) begin
                    n_state = S_DONE;
                end else if (i_sts.last) begin
                    n_state = S_LEAF;
                end else begin
                    n_state = S_READ;
                end
            end
            S_LEAF: begin
                o_cmd.leaf = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/spm_dp.sv
// Datapath with the table store, the page allocator, the walk registers and the result register.
module spm_dp import spm_pkg::*; #(
    parameter int TABLE_PAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    spm_req_if.sink     i_req,
    spm_rsp_if.source   o_rsp,
    spm_cfg_if.sink     i_cfg
);

    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int ADDR_W = PAGE_W + VPN_W;
    localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_PAGE;
    localparam int NF_W   = $clog2(TABLE_PAGES + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [NF_W-1:0]   NF_LIMIT  = NF_W'(TABLE_PAGES);
    localparam logic [PPN_W-1:0]  OFF_LIMIT = PPN_W'(TABLE_PAGES);

    logic [PTE_W-1:0]     r_mem [0:DEPTH-1];
    logic [PTE_W-1:0]     r_rdata;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [PPN_W-1:0]     r_base;
    logic [2*VPN_W-1:0]   r_vpn;
    logic [PTE_W-1:0]     r_leaf;
    logic [LEVEL_W-1:0]   r_level;
    logic                 r_idx;
    logic [ADDR_W-1:0]    r_slot;
    logic [NF_W-1:0]      r_nfree;
    logic [ADDED_W-1:0]   r_added;
    logic [STATUS_W-1:0]  r_status;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [PTE_W-1:0]     r_out_leaf;
    logic [ADDED_W-1:0]   r_out_added;

    logic                 load;
    logic                 ent_v;
    logic [PPN_W-1:0]     ent_ppn;
    logic [PPN_W-1:0]     off;
    logic                 off_ok;
    logic                 pool_full;
    logic                 alloc;
    logic [VPN_W-1:0]     vpn_sel;
    logic [PAGE_W-1:0]    next_page;
    logic [PPN_W-1:0]     new_ppn;
    logic [PTE_W-1:0]     new_ent;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_addr;
    logic [PTE_W-1:0]     mem_wdata;

    assign load      = i_cmd.idle && i_req.valid;
    assign ent_v     = r_rdata[PTE_V_BIT];
    assign ent_ppn   = r_rdata[PPN_LSB +: PPN_W];
    assign off       = ent_ppn - r_base;
    assign off_ok    = off < OFF_LIMIT;
    assign pool_full = r_nfree >= NF_LIMIT;
    assign alloc     = i_cmd.eval && !ent_v && !pool_full;
    assign vpn_sel   = r_idx ? r_vpn[VPN_W +: VPN_W] : r_vpn[0 +: VPN_W];
    assign next_page = ent_v ? off[PAGE_W-1:0] : r_nfree[PAGE_W-1:0];
    assign new_ppn   = r_base + PPN_W'(r_nfree);
    assign new_ent   = {{PTE_PAD_W{1'b0}}, new_ppn, {(PPN_LSB-1){1'b0}}, 1'b1};

    assign mem_we    = i_cmd.clr || alloc || i_cmd.leaf;
    assign mem_addr  = i_cmd.clr ? r_clr_addr : r_slot;
    assign mem_wdata = i_cmd.clr ? '0 : (i_cmd.leaf ? r_leaf : new_ent);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    assign o_sts.clr_last  = r_clr_addr == LAST_ADDR;
    assign o_sts.req_valid = i_req.valid;
    assign o_sts.top       = i_req.leaf_level[1];
    assign o_sts.err       = ent_v ? !off_ok : pool_full;
    assign o_sts.last      = {1'b0, r_idx} == r_level;
    assign o_sts.out_free  = !r_out_valid || o_rsp.ready;

    assign i_req.ready = i_cmd.idle;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_base      <= '0;
            r_nfree     <= NF_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg.valid) begin
                r_base <= i_cfg.pool_base_page;
            end
            if (alloc) begin
                r_nfree <= r_nfree + 1'b1;
            end
            if (i_cmd.done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_vpn    <= i_req.virt_addr[12 +: 2*VPN_W];
            r_leaf   <= {{PTE_PAD_W{1'b0}}, i_req.phys_addr[PA_W-1:12],
                         i_req.leaf_flags[FLAGS_W-1:1], 1'b1};
            r_level  <= i_req.leaf_level[1] ? LEVEL_TOP : i_req.leaf_level;
            r_idx    <= 1'b1;
            r_slot   <= {PAGE_W'(0), i_req.virt_addr[VA_W-1:30]};
            r_added  <= '0;
            r_status <= ST_OK;
        end else if (i_cmd.eval) begin
            r_idx <= 1'b0;
            if (!ent_v) begin
                if (pool_full) begin
                    r_status <= ST_NO_PAGE;
                end else begin
                    r_added <= r_added + 1'b1;
                    r_slot  <= {next_page, vpn_sel};
                end
            end else if (!off_ok) begin
                r_status <= ST_OUTSIDE;
            end else begin
                r_slot <= {next_page, vpn_sel};
            end
        end
        if (i_cmd.done) begin
            r_out_status <= r_status;
            r_out_leaf   <= (r_status == ST_OK) ? r_leaf : '0;
            r_out_added  <= r_added;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.leaf_entry  = r_out_leaf;
    assign o_rsp.pages_added = r_out_added;

    a_nfree_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfree <= NF_LIMIT)
        else $error("Free page index ran past the pool size.");

    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc |=> r_nfree == $past(r_nfree) + 1'b1)
        else $error("Allocation did not advance the free page index.");

    a_leaf_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.leaf |-> r_status == ST_OK)
        else $error("Leaf entry written after a walk error.");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_OK |-> r_out_leaf == '0)
        else $error("Failed transaction reports a nonzero leaf entry.");

endmodule

// File: rtl/sv39_page_table_mapper.sv
// Top level of the Sv39 page table mapper: controller and datapath.
//
//   Port    Direction  Contents
//   i_req   sink       virt_addr, phys_addr, leaf_flags, leaf_level
//   o_rsp   source     status, leaf_entry, pages_added
//   i_cfg   sink       pool_base_page
//
// Each table level walked takes a read and an evaluate step through the single table
// store port, then the leaf entry is written; a 1GiB leaf walks no level, a 4KiB leaf two.
// After reset a clearing pass writes zero to all TABLE_PAGES * 512 entries, one per cycle,
// and no request is taken until it ends; configuration writes are taken at any time.
// The result register holds a finished transaction until o_rsp.ready, while the next
// request is accepted and walked.
module sv39_page_table_mapper import spm_pkg::*; #(
    parameter int TABLE_PAGES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spm_req_if.sink    i_req,
    spm_rsp_if.source  o_rsp,
    spm_cfg_if.sink    i_cfg
);

    t_cmd cmd;
    t_sts sts;

    spm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    spm_dp #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg)
    );

endmodule

// File: sim/tb_top.sv
// Testbench of the Sv39 page table mapper: directed and random map requests against a predictor.
module tb_top;
    import spm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_PAGES = 16;
    localparam int POOL_ENTRIES = POOL_PAGES * ENTRIES_PER_PAGE;
    localparam int SLOT_W = $clog2(POOL_ENTRIES);
    localparam int PHASE_ITEMS = 236;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PTE_W-1:0]    leaf;
        logic [ADDED_W-1:0]  added;
    } t_map_result;

    logic i_clk;
    logic i_rst_n;

    spm_req_if req_ch ();
    spm_rsp_if rsp_ch ();
    spm_cfg_if cfg_ch ();

    sv39_page_table_mapper #(
        .TABLE_PAGES(POOL_PAGES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .i_cfg  (cfg_ch)
    );

    logic [PTE_W-1:0] pte_mirror [0:POOL_ENTRIES-1];
    int unsigned      free_page;
    logic [PPN_W-1:0] pool_base;

    t_map_result      expected_q [$];
    logic [VA_W-1:0]  live_paths [$];
    int               mismatches = 0;
    bit               calm = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_map_result predict_map(input logic [VA_W-1:0] va,
                                                input logic [PA_W-1:0] pa,
                                                input logic [FLAGS_W-1:0] flags,
                                                input logic [LEVEL_W-1:0] lvl);
        t_map_result       r;
        logic [VPN_W-1:0]  vpn [3];
        logic [PTE_W-1:0]  pte;
        logic [PPN_W-1:0]  off;
        logic [SLOT_W-1:0] slot;
        int                depth;
        int                stop;
        r = '0;
        r.status = ST_OK;
        stop = (lvl > LEVEL_TOP) ? int'(LEVEL_TOP) : int'(lvl);
        vpn[0] = va[20:12];
        vpn[1] = va[29:21];
        vpn[2] = va[38:30];
        slot = SLOT_W'(vpn[2]);
        for (depth = 1; depth >= stop && r.status == ST_OK; depth--) begin
            pte = pte_mirror[slot];
            if (!pte[PTE_V_BIT]) begin
                if (free_page >= POOL_PAGES) begin
                    r.status = ST_NO_PAGE;
                end else begin
                    pte = {{PTE_PAD_W{1'b0}}, pool_base + PPN_W'(free_page),
                           {(PPN_LSB-1){1'b0}}, 1'b1};
                    pte_mirror[slot] = pte;
                    free_page++;
                    r.added++;
                end
            end
            if (r.status == ST_OK) begin
                off = pte[PPN_LSB +: PPN_W] - pool_base;
                if (off >= POOL_PAGES) begin
                    r.status = ST_OUTSIDE;
                end else begin
                    slot = SLOT_W'(int'(off) * ENTRIES_PER_PAGE + int'(vpn[depth]));
                end
            end
        end
        if (r.status == ST_OK) begin
            r.leaf = {{PTE_PAD_W{1'b0}}, pa[PA_W-1:12], flags[FLAGS_W-1:1], 1'b1};
            pte_mirror[slot] = r.leaf;
        end
        return r;
    endfunction

    task automatic send_map(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
                            input logic [FLAGS_W-1:0] flags, input logic [LEVEL_W-1:0] lvl);
        t_map_result r;
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.virt_addr  <= va;
        req_ch.phys_addr  <= pa;
        req_ch.leaf_flags <= flags;
        req_ch.leaf_level <= lvl;
        do @(posedge i_clk); while (!req_ch.ready);
        r = predict_map(va, pa, flags, lvl);
        if (r.status == ST_OK && lvl == 0) live_paths.push_back(va);
        expected_q.push_back(r);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    task automatic write_pool_base(input logic [PPN_W-1:0] value);
        drain_results();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.pool_base_page <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        pool_base = value;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_leaf_levels();
        write_pool_base('0);
        send_map('0, '0, '0, 2'd0);
        send_map('1, '1, '1, 2'd3);
        send_map({9'h1FF, 9'h005, 9'h000, 12'h000}, PA_W'(rand64()), 10'h155, 2'd1);
        send_map({9'h001, 9'h000, 9'h000, 12'h000}, 56'h3 << 12, 10'h2AA, 2'd1);
        send_map({9'h000, 9'h000, 9'h1FF, 12'hFFF}, PA_W'(rand64()), 10'h0CE, 2'd0);
        send_map({9'h001, 9'h000, 9'h011, 12'h000}, PA_W'(rand64()), '0, 2'd0);
        send_map({9'h002, 30'h05A5A5A5}, PA_W'(rand64()) | 56'h1FF_F000, '0, 2'd2);
        send_map({9'h003, 9'h1FF, 21'h0}, '1, 10'h001, 2'd1);
    endtask

    task automatic test_pool_exhaustion();
        int k;
        k = 0;
        while (free_page < POOL_PAGES - 1) begin
            send_map({9'h100 + 9'(k), 9'h000, 9'h000, 12'h000}, PA_W'(rand64()),
                     FLAGS_W'(rand64()), 2'd0);
            k++;
        end
        if (free_page < POOL_PAGES) begin
            send_map({9'h180, 9'h000, 9'h000, 12'h000}, PA_W'(rand64()),
                     FLAGS_W'(rand64()), 2'd1);
        end
        send_map({9'h181, 9'h000, 9'h000, 12'h000}, PA_W'(rand64()), FLAGS_W'(rand64()), 2'd0);
        send_map({9'h182, 9'h000, 9'h000, 12'h000}, PA_W'(rand64()), FLAGS_W'(rand64()), 2'd0);
    endtask

    task automatic test_outside_pool();
        write_pool_base(44'd5);
        send_map({9'h000, 9'h000, 9'h002, 12'h000}, PA_W'(rand64()), FLAGS_W'(rand64()), 2'd0);
        write_pool_base('1);
        send_map({9'h000, 9'h000, 9'h003, 12'h000}, PA_W'(rand64()), FLAGS_W'(rand64()), 2'd0);
        write_pool_base('0);
        send_map({9'h000, 9'h000, 9'h004, 12'h000}, PA_W'(rand64()), FLAGS_W'(rand64()), 2'd0);
    endtask

    task automatic test_random_maps(input logic [PPN_W-1:0] base, input bit quiet);
        logic [VA_W-1:0]    va;
        logic [LEVEL_W-1:0] lvl;
        int                 pick;
        write_pool_base(base);
        calm = quiet;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            va = VA_W'(rand64());
            lvl = LEVEL_W'($urandom_range(0, 3));
            if (live_paths.size() != 0 && $urandom_range(0, 9) < 7) begin
                va[VA_W-1:21] = live_paths[$urandom_range(0, live_paths.size() - 1)][VA_W-1:21];
                pick = $urandom_range(0, 19);
                lvl = (pick == 0) ? 2'd1 : (pick == 1) ? 2'd2 : 2'd0;
            end
            send_map(va, PA_W'(rand64()), FLAGS_W'(rand64()), lvl);
        end
        drain_results();
    endtask

    initial begin : stall_rsp
        rsp_ch.ready = 1'b0;
        forever begin
            int hold;
            hold = 0;
            @(posedge i_clk);
            if (hold == 0 && !calm && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 12);
            end
            while (hold > 0) begin
                rsp_ch.ready <= 1'b0;
                hold--;
                @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_rsp
        t_map_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transaction status %0d leaf %h added %0d",
                         $time, rsp_ch.status, rsp_ch.leaf_entry, rsp_ch.pages_added);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.leaf_entry !== want.leaf) begin
                    $display("%0t: leaf_entry expected %h actual %h",
                             $time, want.leaf, rsp_ch.leaf_entry);
                    mismatches++;
                end
                if (rsp_ch.pages_added !== want.added) begin
                    $display("%0t: pages_added expected %0d actual %0d",
                             $time, want.added, rsp_ch.pages_added);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #4ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.virt_addr = '0;
        req_ch.phys_addr = '0;
        req_ch.leaf_flags = '0;
        req_ch.leaf_level = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.pool_base_page = '0;
        for (int i = 0; i < POOL_ENTRIES; i++) pte_mirror[i] = '0;
        free_page = 1;
        pool_base = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_leaf_levels();
        test_pool_exhaustion();
        test_outside_pool();
        test_random_maps('0, 1'b0);
        test_random_maps(PPN_W'(rand64()), 1'b0);
        test_random_maps('1, 1'b0);
        test_random_maps(PPN_W'($urandom_range(1, POOL_PAGES - 1)), 1'b0);
        test_random_maps('0, 1'b1);

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/spm_pkg.sv
rtl/spm_if.sv
rtl/spm_ctrl.sv
rtl/spm_dp.sv
rtl/sv39_page_table_mapper.sv
sim/tb_top.sv
